FILE: rtl/core/apc_pkg.sv
// shared types and constants for the attenuator position controller
`timescale 1ns / 1ps

package apc_pkg;

    localparam int unsigned MV_W    = 12;
    localparam int unsigned DB_W    = 8;
    localparam int unsigned SLOPE_W = 10;
    localparam int unsigned EPS_W   = 8;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [SLOPE_W-1:0] SLOPE_RESET = 10'd100;
    localparam logic [EPS_W-1:0]   EPS_RESET   = 8'd20;

    // register index, taken from paddr[2]
    localparam logic REG_SLOPE = 1'b0;
    localparam logic REG_EPS   = 1'b1;

    typedef enum logic [1:0] {
        REQ_CMD    = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_TICK   = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        PH_FIND_MAX = 3'd0,
        PH_FIND_MIN = 3'd1,
        PH_IDLE     = 3'd2,
        PH_FWD      = 3'd3,
        PH_REV      = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_REACHED = 3'd1,
        ST_STALLED = 3'd2,
        ST_CALDONE = 3'd3,
        ST_BUSY    = 3'd4
    } t_status;

    typedef struct packed {
        logic [SLOPE_W-1:0] slope_mv_per_db;
        logic [EPS_W-1:0]   stall_eps_mv;
    } t_cfg;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [DB_W-1:0] attenuation_db;
        logic [MV_W-1:0] sample_mv;
    } t_item;

    typedef struct packed {
        t_phase          phase;
        logic [MV_W-1:0] min_mv;
        logic [MV_W-1:0] max_mv;
        logic [MV_W-1:0] latest_mv;
        logic [MV_W-1:0] reference_mv;
        logic [MV_W-1:0] target_mv;
    } t_ctl_state;

    typedef struct packed {
        logic            drive_enable;
        logic            drive_reverse;
        logic [2:0]      phase_now;
        logic [2:0]      status_code;
        logic [MV_W-1:0] target_now_mv;
    } t_result;

endpackage

FILE: rtl/core/apc_ifs.sv
// valid/ready channel interfaces for request and result beats
`timescale 1ns / 1ps

interface apc_item_if;
    import apc_pkg::*;
    logic            valid;
    logic            ready;
    logic [1:0]      req_type;
    logic [DB_W-1:0] attenuation_db;
    logic [MV_W-1:0] sample_mv;

    modport source (output valid, output req_type, output attenuation_db,
                    output sample_mv, input ready);
    modport sink   (input valid, input req_type, input attenuation_db,
                    input sample_mv, output ready);
endinterface

interface apc_result_if;
    import apc_pkg::*;
    logic            valid;
    logic            ready;
    logic            drive_enable;
    logic            drive_reverse;
    logic [2:0]      phase_now;
    logic [2:0]      status_code;
    logic [MV_W-1:0] target_now_mv;

    modport source (output valid, output drive_enable, output drive_reverse,
                    output phase_now, output status_code, output target_now_mv,
                    input ready);
    modport sink   (input valid, input drive_enable, input drive_reverse,
                    input phase_now, input status_code, input target_now_mv,
                    output ready);
endinterface

FILE: rtl/core/apc_cfg_regs.sv
// apb configuration registers: slope and stall threshold
`timescale 1ns / 1ps

module apc_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [apc_pkg::ADDR_W-1:0]  paddr,
    input  logic [apc_pkg::DATA_W-1:0]  pwdata,
    output logic [apc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output apc_pkg::t_cfg               o_cfg
);
    import apc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;
    logic w_idx;

    assign pready = 1'b1;
    // low address bits are ignored, register select is bit 2
    assign w_idx  = paddr[2];
    assign w_wr   = psel & penable & pwrite & pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_SLOPE: n_cfg.slope_mv_per_db = pwdata[SLOPE_W-1:0];
                REG_EPS:   n_cfg.stall_eps_mv    = pwdata[EPS_W-1:0];
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slope_mv_per_db <= SLOPE_RESET;
            r_cfg.stall_eps_mv    <= EPS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_SLOPE: prdata = {{(DATA_W-SLOPE_W){1'b0}}, r_cfg.slope_mv_per_db};
            REG_EPS:   prdata = {{(DATA_W-EPS_W){1'b0}}, r_cfg.stall_eps_mv};
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/apc_step.sv
// per-beat next-state and result logic of the position controller
`timescale 1ns / 1ps

module apc_step (
    input  apc_pkg::t_ctl_state i_st,
    input  apc_pkg::t_item      i_item,
    input  apc_pkg::t_cfg       i_cfg,
    output apc_pkg::t_ctl_state o_st,
    output apc_pkg::t_result    o_res
);
    import apc_pkg::*;

    localparam int unsigned PROD_W = DB_W + SLOPE_W;

    t_ctl_state        n_st;
    t_status           n_status;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W:0]   w_sum;
    logic [MV_W-1:0]   w_tgt;
    logic [MV_W-1:0]   w_diff;
    logic              w_still;

    // target = db * slope + min, upper clamp checked first
    assign w_prod = {{SLOPE_W{1'b0}}, i_item.attenuation_db}
                  * {{DB_W{1'b0}}, i_cfg.slope_mv_per_db};
    assign w_sum  = {1'b0, w_prod} + {{(PROD_W+1-MV_W){1'b0}}, i_st.min_mv};

    always_comb begin
        if (w_sum > {{(PROD_W+1-MV_W){1'b0}}, i_st.max_mv}) begin
            w_tgt = i_st.max_mv;
        end else if (w_sum < {{(PROD_W+1-MV_W){1'b0}}, i_st.min_mv}) begin
            w_tgt = i_st.min_mv;
        end else begin
            w_tgt = w_sum[MV_W-1:0];
        end
    end

    assign w_diff  = (i_st.latest_mv >= i_st.reference_mv)
                   ? (i_st.latest_mv - i_st.reference_mv)
                   : (i_st.reference_mv - i_st.latest_mv);
    assign w_still = (w_diff <= {{(MV_W-EPS_W){1'b0}}, i_cfg.stall_eps_mv});

    // next state
    always_comb begin
        n_st     = i_st;
        n_status = ST_NONE;
        case (i_item.req_type)
            REQ_CMD: begin
                if (i_st.phase != PH_IDLE) begin
                    n_status = ST_BUSY;
                end else begin
                    n_st.target_mv    = w_tgt;
                    n_st.reference_mv = '0;
                    if (i_st.latest_mv < w_tgt) begin
                        n_st.phase = PH_FWD;
                    end else if (i_st.latest_mv > w_tgt) begin
                        n_st.phase = PH_REV;
                    end else begin
                        n_status = ST_REACHED;
                    end
                end
            end
            REQ_SAMPLE: begin
                n_st.latest_mv = i_item.sample_mv;
                if ((i_st.phase == PH_FWD && i_item.sample_mv >= i_st.target_mv) ||
                    (i_st.phase == PH_REV && i_item.sample_mv <= i_st.target_mv)) begin
                    n_st.phase = PH_IDLE;
                    n_status   = ST_REACHED;
                end
            end
            REQ_TICK: begin
                if (i_st.phase != PH_IDLE) begin
                    n_st.reference_mv = i_st.latest_mv;
                    if (w_still) begin
                        case (i_st.phase)
                            PH_FIND_MAX: begin
                                n_st.max_mv       = i_st.latest_mv;
                                n_st.phase        = PH_FIND_MIN;
                                n_st.reference_mv = '0;
                                n_status          = ST_CALDONE;
                            end
                            PH_FIND_MIN: begin
                                n_st.min_mv = i_st.latest_mv;
                                n_st.phase  = PH_IDLE;
                                n_status    = ST_CALDONE;
                            end
                            default: begin
                                n_st.phase = PH_IDLE;
                                n_status   = ST_STALLED;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_st     = i_st;
                n_status = ST_NONE;
            end
        endcase
    end

    // result fields show the state after the beat
    always_comb begin
        o_res.drive_enable  = (n_st.phase != PH_IDLE);
        o_res.drive_reverse = (n_st.phase == PH_FIND_MIN) || (n_st.phase == PH_REV);
        o_res.phase_now     = n_st.phase;
        o_res.status_code   = n_status;
        o_res.target_now_mv = n_st.target_mv;
    end

    assign o_st = n_st;

endmodule

FILE: rtl/core/attenuator_position_controller.sv
// top level: request register, controller state, result register, apb port
//
//  channel   dir  handshake     payload
//  i_item    in   valid/ready   req_type, attenuation_db, sample_mv
//  o_result  out  valid/ready   drive_enable, drive_reverse, phase_now,
//                               status_code, target_now_mv
//  apb       in   psel/penable  slope_mv_per_db (0x0), stall_eps_mv (0x4)
//
// one beat per cycle sustained while o_result is not stalled; a request passes the request
// register, then the state update writes its result beat into the result register
// reset starts calibration: motor forward to find the maximum
// a stalled result register holds the request register; both sides run freely
// otherwise, so a new request is taken while a result waits
`timescale 1ns / 1ps

module attenuator_position_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    apc_item_if.sink                    i_item,
    apc_result_if.source                o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [apc_pkg::ADDR_W-1:0]  paddr,
    input  logic [apc_pkg::DATA_W-1:0]  pwdata,
    output logic [apc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import apc_pkg::*;

    t_cfg       w_cfg;
    t_item      w_item_in;
    t_item      r_item;
    logic       r_item_valid;
    t_ctl_state r_st;
    t_ctl_state n_st;
    t_result    w_res;
    t_result    r_res;
    logic       r_res_valid;
    logic       w_adv;
    logic       w_in_take;

    apc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    apc_step u_step (
        .i_st   (r_st),
        .i_item (r_item),
        .i_cfg  (w_cfg),
        .o_st   (n_st),
        .o_res  (w_res)
    );

    assign w_item_in.req_type       = i_item.req_type;
    assign w_item_in.attenuation_db = i_item.attenuation_db;
    assign w_item_in.sample_mv      = i_item.sample_mv;

    // the request register moves on when the result register is free or drains
    assign w_adv       = r_item_valid & (~r_res_valid | o_result.ready);
    assign i_item.ready = ~r_item_valid | w_adv;
    assign w_in_take   = i_item.valid & i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_res_valid  <= 1'b0;
            r_st.phase        <= PH_FIND_MAX;
            r_st.min_mv       <= '0;
            r_st.max_mv       <= '0;
            r_st.latest_mv    <= '0;
            r_st.reference_mv <= '0;
            r_st.target_mv    <= '0;
        end else begin
            if (i_item.ready) begin
                r_item_valid <= i_item.valid;
            end
            if (w_adv) begin
                r_st        <= n_st;
                r_res_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item <= w_item_in;
        end
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_result.valid         = r_res_valid;
    assign o_result.drive_enable  = r_res.drive_enable;
    assign o_result.drive_reverse = r_res.drive_reverse;
    assign o_result.phase_now     = r_res.phase_now;
    assign o_result.status_code   = r_res.status_code;
    assign o_result.target_now_mv = r_res.target_now_mv;

`ifndef SYNTHESIS
    // calibration never restarts once it has left the find-max phase
    a_no_recal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase != PH_FIND_MAX) |=> (r_st.phase != PH_FIND_MAX))
        else $error("find-max phase re-entered");

    // a move always heads for a target inside the calibrated range
    a_tgt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_st.phase == PH_FWD || r_st.phase == PH_REV) && r_st.min_mv <= r_st.max_mv)
        |-> (r_st.target_mv >= r_st.min_mv && r_st.target_mv <= r_st.max_mv))
        else $error("target outside calibrated range");

    // reached or stalled always leaves the motor off
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && (r_res.status_code == ST_REACHED ||
                         r_res.status_code == ST_STALLED))
        |-> (r_res.phase_now == PH_IDLE && !r_res.drive_enable))
        else $error("stop status with motor driven");

    // a held result beat is not overwritten
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !o_result.ready) |=> (r_res_valid && $stable(r_res)))
        else $error("pending result beat lost");
`endif

endmodule
